>>> hw/rtl/fhs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fhs_pkg
// Shared types and constants for the floor heading selector: register map,
// color bound bundle and the control groups passed between pipeline stages.
// ----------------------------------------------------------------------------
package fhs_pkg;

  // configuration port geometry
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 9;

  // result field widths
  localparam int BEST_ROW_W = 10;
  localparam int SUM_W      = 13;
  localparam logic [SUM_W-1:0] SUM_MAX = 13'd8191;

  // register reset values
  localparam logic [7:0] LUMA_LOW_RST       = 8'd0;
  localparam logic [7:0] LUMA_HIGH_RST      = 8'd100;
  localparam logic [7:0] BLUE_DIFF_LOW_RST  = 8'd0;
  localparam logic [7:0] BLUE_DIFF_HIGH_RST = 8'd120;
  localparam logic [7:0] RED_DIFF_LOW_RST   = 8'd0;
  localparam logic [7:0] RED_DIFF_HIGH_RST  = 8'd130;
  localparam logic [8:0] ROW_WIDTH_RST      = 9'd240;

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LUMA_LOW       = 3'd0,
    REG_LUMA_HIGH      = 3'd1,
    REG_BLUE_DIFF_LOW  = 3'd2,
    REG_BLUE_DIFF_HIGH = 3'd3,
    REG_RED_DIFF_LOW   = 3'd4,
    REG_RED_DIFF_HIGH  = 3'd5,
    REG_ROW_WIDTH      = 3'd6
  } cfg_reg_t;

  // classification bounds and row geometry
  typedef struct packed {
    logic [7:0] luma_low;
    logic [7:0] luma_high;
    logic [7:0] blue_diff_low;
    logic [7:0] blue_diff_high;
    logic [7:0] red_diff_low;
    logic [7:0] red_diff_high;
    logic [8:0] row_width;
  } bounds_t;

  // row accumulator -> window stage
  typedef struct packed {
    logic valid;   // a row closed on this item
    logic frame;   // the item also closed the frame
  } row_ev_t;

  // window stage -> best tracker
  typedef struct packed {
    logic valid;   // an event is present
    logic cand;    // a full window was credited to a centre row
    logic frame;   // frame closes after this event
  } cand_ctl_t;

endpackage

>>> hw/rtl/fhs_row_accum.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fhs_row_accum
// Classifies both pixels of a registered pair against the color bounds and
// keeps the per-row floor count with mat fill over the first half of the row.
// ----------------------------------------------------------------------------
module fhs_row_accum
  import fhs_pkg::*;
#(
  parameter int MAX_WIDTH = 256,
  parameter int CNT_W     = 9
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             pair_valid,
  input  bounds_t          bounds,
  input  logic [7:0]       chroma_u,
  input  logic [7:0]       luma_even,
  input  logic [7:0]       chroma_v,
  input  logic [7:0]       luma_odd,
  input  logic             row_end,
  input  logic             frame_end,
  output row_ev_t          ev,
  output logic [CNT_W-1:0] ev_count
);

  localparam int COL_W = $clog2(MAX_WIDTH + 1);

  logic [COL_W-1:0] col, col_mid, col_next;
  logic             prev, prev_mid, prev_next;
  logic [CNT_W-1:0] cnt, cnt_mid, cnt_next;
  logic             chroma_ok, fl0, fl1;
  logic [8:0]       half;
  logic             row_close;

  // color classification, chroma shared by the pair
  assign chroma_ok = (chroma_u >= bounds.blue_diff_low) && (chroma_u <= bounds.blue_diff_high) &&
                     (chroma_v >= bounds.red_diff_low) && (chroma_v <= bounds.red_diff_high);
  assign fl0 = chroma_ok && (luma_even >= bounds.luma_low) && (luma_even <= bounds.luma_high);
  assign fl1 = chroma_ok && (luma_odd >= bounds.luma_low) && (luma_odd <= bounds.luma_high);
  assign half = {1'b0, bounds.row_width[8:1]};
  assign row_close = row_end || frame_end;

  // two pixel steps, even column first
  always_comb begin
    col_mid  = col;
    prev_mid = prev;
    cnt_mid  = cnt;
    if (col < COL_W'(MAX_WIDTH)) begin
      if (fl0) begin
        if ((col != '0) && (9'(col) < half) && !prev) begin
          cnt_mid = CNT_W'(col) + CNT_W'(1);
        end else begin
          cnt_mid = cnt + CNT_W'(1);
        end
      end
      prev_mid = fl0;
      col_mid  = col + COL_W'(1);
    end
    col_next  = col_mid;
    prev_next = prev_mid;
    cnt_next  = cnt_mid;
    if (col_mid < COL_W'(MAX_WIDTH)) begin
      if (fl1) begin
        if ((col_mid != '0) && (9'(col_mid) < half) && !prev_mid) begin
          cnt_next = CNT_W'(col_mid) + CNT_W'(1);
        end else begin
          cnt_next = cnt_mid + CNT_W'(1);
        end
      end
      prev_next = fl1;
      col_next  = col_mid + COL_W'(1);
    end
  end

  // row state and row-close event register
  always_ff @(posedge clk) begin
    if (rst) begin
      col      <= '0;
      prev     <= 1'b0;
      cnt      <= '0;
      ev       <= '0;
      ev_count <= '0;
    end else if (en) begin
      ev.valid <= pair_valid && row_close;
      ev.frame <= pair_valid && frame_end;
      ev_count <= cnt_next;
      if (pair_valid) begin
        if (row_close) begin
          col  <= '0;
          prev <= 1'b0;
          cnt  <= '0;
        end else begin
          col  <= col_next;
          prev <= prev_next;
          cnt  <= cnt_next;
        end
      end
    end
  end

  // the running count never passes the number of pixels taken
  a_cnt_le_col: assert property (@(posedge clk) disable iff (rst)
    COL_W'(cnt) <= col)
    else $error("row floor count exceeds column index");

endmodule

>>> hw/rtl/fhs_window.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fhs_window
// Boxcar over the last WINDOW row counts held in a shift line; produces the
// window total and its centre row for every counted row.
// ----------------------------------------------------------------------------
module fhs_window
  import fhs_pkg::*;
#(
  parameter int WINDOW   = 25,
  parameter int MAX_ROWS = 1024,
  parameter int CNT_W    = 9,
  parameter int TOT_W    = 13,
  parameter int CTR_W    = 10
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  row_ev_t          ev,
  input  logic [CNT_W-1:0] ev_count,
  output cand_ctl_t        cand,
  output logic [TOT_W-1:0] cand_total,
  output logic [CTR_W-1:0] cand_centre
);

  localparam int ROW_W = $clog2(MAX_ROWS + 1);
  localparam int OFF   = WINDOW - (WINDOW - 1) / 2;

  logic [CNT_W-1:0] taps [WINDOW];
  logic [TOT_W-1:0] total, total_next;
  logic [ROW_W-1:0] row_index, row_next;
  logic             counted;

  // window update for a counted row
  assign counted    = row_index < ROW_W'(MAX_ROWS);
  assign total_next = total - TOT_W'(taps[WINDOW-1]) + TOT_W'(ev_count);
  assign row_next   = row_index + ROW_W'(1);

  // shift line, totals and candidate register
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < WINDOW; i++) begin
        taps[i] <= '0;
      end
      total       <= '0;
      row_index   <= '0;
      cand        <= '0;
      cand_total  <= '0;
      cand_centre <= '0;
    end else if (en) begin
      cand.valid  <= ev.valid;
      cand.frame  <= ev.frame;
      cand.cand   <= ev.valid && counted && (row_next >= ROW_W'(WINDOW));
      cand_total  <= total_next;
      cand_centre <= CTR_W'(row_next - ROW_W'(OFF));
      if (ev.valid) begin
        if (ev.frame) begin
          for (int i = 0; i < WINDOW; i++) begin
            taps[i] <= '0;
          end
          total     <= '0;
          row_index <= '0;
        end else if (counted) begin
          taps[0] <= ev_count;
          for (int i = 1; i < WINDOW; i++) begin
            taps[i] <= taps[i-1];
          end
          total     <= total_next;
          row_index <= row_next;
        end
      end
    end
  end

  a_total_bound: assert property (@(posedge clk) disable iff (rst)
    (ev.valid && counted) |-> (total_next >= TOT_W'(ev_count)))
    else $error("window total lost a row count");

  a_frame_clear: assert property (@(posedge clk) disable iff (rst)
    (en && ev.valid && ev.frame) |=> (row_index == '0 && total == '0))
    else $error("frame state not cleared after frame end");

endmodule

>>> hw/rtl/fhs_best.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fhs_best
// Tracks the first centre with the largest window total over a frame and
// holds the frame result in the output register until it is taken.
// ----------------------------------------------------------------------------
module fhs_best
  import fhs_pkg::*;
#(
  parameter int TOT_W = 13,
  parameter int CTR_W = 10
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  cand_ctl_t             cand,
  input  logic [TOT_W-1:0]      cand_total,
  input  logic [CTR_W-1:0]      cand_centre,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [BEST_ROW_W-1:0] best_row,
  output logic [SUM_W-1:0]      best_floor_sum,
  output logic                  found
);

  localparam int EXT_W = (TOT_W > SUM_W) ? TOT_W : SUM_W;

  logic [TOT_W-1:0] best_total, total_next;
  logic [CTR_W-1:0] best_centre, centre_next;
  logic [EXT_W-1:0] total_ext;
  logic             take;

  // strictly larger replaces, so ties keep the earliest centre
  assign take        = cand.valid && cand.cand && (cand_total > best_total);
  assign total_next  = take ? cand_total : best_total;
  assign centre_next = take ? cand_centre : best_centre;
  assign total_ext   = EXT_W'(total_next);

  // best tracking and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      best_total     <= '0;
      best_centre    <= '0;
      out_valid      <= 1'b0;
      best_row       <= '0;
      best_floor_sum <= '0;
      found          <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (en && cand.valid) begin
        if (cand.frame) begin
          best_total  <= '0;
          best_centre <= '0;
          out_valid   <= 1'b1;
          found       <= total_next != '0;
          if (total_next != '0) begin
            best_row       <= BEST_ROW_W'(centre_next);
            best_floor_sum <= (total_ext > EXT_W'(SUM_MAX)) ? SUM_MAX : SUM_W'(total_ext);
          end else begin
            best_row       <= '0;
            best_floor_sum <= '0;
          end
        end else begin
          best_total  <= total_next;
          best_centre <= centre_next;
        end
      end
    end
  end

  a_found_sum: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (found == (best_floor_sum != '0)))
    else $error("found flag disagrees with reported sum");

endmodule

>>> hw/rtl/floor_heading_selector.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// floor_heading_selector
// A frame result passes the input, row event, candidate and result registers.
// Throughput: one pixel pair per clock, set by the single-pass row update.
// The input stalls only while a frame result waits and a second one is ready.
// Reset (rst, synchronous): control and configuration registers return to their defaults, frame state
// and the window shift line clear at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module floor_heading_selector
  import fhs_pkg::*;
#(
  parameter int WINDOW    = 25,
  parameter int MAX_WIDTH = 256,
  parameter int MAX_ROWS  = 1024
) (
  input  logic                  clk,
  input  logic                  rst,
  // configuration
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // pixel pair input
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [7:0]            chroma_u,
  input  logic [7:0]            luma_even,
  input  logic [7:0]            chroma_v,
  input  logic [7:0]            luma_odd,
  input  logic                  row_end,
  input  logic                  frame_end,
  // frame result
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [BEST_ROW_W-1:0] best_row,
  output logic [SUM_W-1:0]      best_floor_sum,
  output logic                  found
);

  localparam int CNT_W = $clog2(MAX_WIDTH + 1);
  localparam int TOT_W = $clog2(WINDOW * MAX_WIDTH + 1);
  localparam int CTR_W = $clog2(MAX_ROWS);

  bounds_t          bounds;
  logic             en;
  logic             pair_valid;
  logic [7:0]       u_q, ye_q, v_q, yo_q;
  logic             row_end_q, frame_end_q;
  row_ev_t          ev;
  logic [CNT_W-1:0] ev_count;
  cand_ctl_t        cand;
  logic [TOT_W-1:0] cand_total;
  logic [CTR_W-1:0] cand_centre;

  // hold the pipeline only when a second result meets a waiting one
  assign en       = !(cand.valid && cand.frame && out_valid && out_stall);
  assign in_stall = !en;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      bounds.luma_low       <= LUMA_LOW_RST;
      bounds.luma_high      <= LUMA_HIGH_RST;
      bounds.blue_diff_low  <= BLUE_DIFF_LOW_RST;
      bounds.blue_diff_high <= BLUE_DIFF_HIGH_RST;
      bounds.red_diff_low   <= RED_DIFF_LOW_RST;
      bounds.red_diff_high  <= RED_DIFF_HIGH_RST;
      bounds.row_width      <= ROW_WIDTH_RST;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_LUMA_LOW:       bounds.luma_low       <= cfg_data[7:0];
        REG_LUMA_HIGH:      bounds.luma_high      <= cfg_data[7:0];
        REG_BLUE_DIFF_LOW:  bounds.blue_diff_low  <= cfg_data[7:0];
        REG_BLUE_DIFF_HIGH: bounds.blue_diff_high <= cfg_data[7:0];
        REG_RED_DIFF_LOW:   bounds.red_diff_low   <= cfg_data[7:0];
        REG_RED_DIFF_HIGH:  bounds.red_diff_high  <= cfg_data[7:0];
        REG_ROW_WIDTH:      bounds.row_width      <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      pair_valid <= 1'b0;
    end else if (en) begin
      pair_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en && in_valid) begin
      u_q         <= chroma_u;
      ye_q        <= luma_even;
      v_q         <= chroma_v;
      yo_q        <= luma_odd;
      row_end_q   <= row_end;
      frame_end_q <= frame_end;
    end
  end

  fhs_row_accum #(
    .MAX_WIDTH (MAX_WIDTH),
    .CNT_W     (CNT_W)
  ) u_row_accum (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .pair_valid (pair_valid),
    .bounds     (bounds),
    .chroma_u   (u_q),
    .luma_even  (ye_q),
    .chroma_v   (v_q),
    .luma_odd   (yo_q),
    .row_end    (row_end_q),
    .frame_end  (frame_end_q),
    .ev         (ev),
    .ev_count   (ev_count)
  );

  fhs_window #(
    .WINDOW   (WINDOW),
    .MAX_ROWS (MAX_ROWS),
    .CNT_W    (CNT_W),
    .TOT_W    (TOT_W),
    .CTR_W    (CTR_W)
  ) u_window (
    .clk         (clk),
    .rst         (rst),
    .en          (en),
    .ev          (ev),
    .ev_count    (ev_count),
    .cand        (cand),
    .cand_total  (cand_total),
    .cand_centre (cand_centre)
  );

  fhs_best #(
    .TOT_W (TOT_W),
    .CTR_W (CTR_W)
  ) u_best (
    .clk            (clk),
    .rst            (rst),
    .en             (en),
    .cand           (cand),
    .cand_total     (cand_total),
    .cand_centre    (cand_centre),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .best_row       (best_row),
    .best_floor_sum (best_floor_sum),
    .found          (found)
  );

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && cand.valid && cand.frame))
    else $error("input stalled without a waiting result");

endmodule

>>> sim/tb_floor_heading_selector.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_floor_heading_selector
// Self-checking bench for the floor heading selector. Pixel-pair frames of
// random shape and content are pushed through the block under several bound
// and row width settings. A scoreboard predicts the per-frame winner of the
// row-count boxcar and checks each result in order. Both handshake sides
// idle at random, and the result side is held off once per idle profile so
// that the block backs up into its input.
// ----------------------------------------------------------------------------
module tb_floor_heading_selector;
  import fhs_pkg::*;

  localparam int WIN           = 25;
  localparam int MAX_W         = 256;
  localparam int MAX_R         = 1024;
  localparam int RANDOM_ITEMS  = 700;
  localparam int MIN_FRAMES    = 48;
  localparam int HOLD_CYCLES   = 80;
  localparam int SETTLE_CYCLES = 8;
  localparam int WATCHDOG      = 2000;

  // index with no register behind it
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 3'd7;

  typedef struct packed {
    logic [BEST_ROW_W-1:0] centre;
    logic [SUM_W-1:0]      total;
    logic                  hit;
  } frame_result_t;

  // --------------------------------------------------------------------------
  // frame winner prediction and result checking
  // --------------------------------------------------------------------------
  class floor_scoreboard #(int ROWS_IN_WIN = 25, int WIDTH_CAP = 256, int ROW_CAP = 1024);
    bounds_t       bounds;
    int unsigned   col_pos;
    int unsigned   row_pixels;
    int unsigned   rows_done;
    int unsigned   slot;
    int unsigned   win_sum;
    int unsigned   top_sum;
    int unsigned   top_centre;
    bit            last_was_floor;
    int unsigned   row_hist[ROWS_IN_WIN];
    frame_result_t winners_q[$];
    int unsigned   mismatches;
    int unsigned   results_seen;

    function new();
      bounds.luma_low       = LUMA_LOW_RST;
      bounds.luma_high      = LUMA_HIGH_RST;
      bounds.blue_diff_low  = BLUE_DIFF_LOW_RST;
      bounds.blue_diff_high = BLUE_DIFF_HIGH_RST;
      bounds.red_diff_low   = RED_DIFF_LOW_RST;
      bounds.red_diff_high  = RED_DIFF_HIGH_RST;
      bounds.row_width      = ROW_WIDTH_RST;
      mismatches   = 0;
      results_seen = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      col_pos        = 0;
      row_pixels     = 0;
      rows_done      = 0;
      slot           = 0;
      win_sum        = 0;
      top_sum        = 0;
      top_centre     = 0;
      last_was_floor = 1'b0;
      foreach (row_hist[i]) row_hist[i] = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_LUMA_LOW:       bounds.luma_low       = val[7:0];
        REG_LUMA_HIGH:      bounds.luma_high      = val[7:0];
        REG_BLUE_DIFF_LOW:  bounds.blue_diff_low  = val[7:0];
        REG_BLUE_DIFF_HIGH: bounds.blue_diff_high = val[7:0];
        REG_RED_DIFF_LOW:   bounds.red_diff_low   = val[7:0];
        REG_RED_DIFF_HIGH:  bounds.red_diff_high  = val[7:0];
        REG_ROW_WIDTH:      bounds.row_width      = val;
        default: ;
      endcase
    endfunction

    // one pixel: classify, then apply the mat fill or a plain count
    function void take_pixel(logic [7:0] y, logic [7:0] u, logic [7:0] v);
      int unsigned half;
      bit          fl;
      half = bounds.row_width >> 1;
      if (col_pos >= WIDTH_CAP) return;
      fl = y >= bounds.luma_low && y <= bounds.luma_high &&
           u >= bounds.blue_diff_low && u <= bounds.blue_diff_high &&
           v >= bounds.red_diff_low && v <= bounds.red_diff_high;
      if (fl) begin
        if (col_pos >= 1 && col_pos < half && !last_was_floor) row_pixels = col_pos + 1;
        else row_pixels++;
      end
      last_was_floor = fl;
      col_pos++;
    endfunction

    // push the row count into the boxcar and track the first best centre
    function void close_row();
      if (rows_done < ROW_CAP) begin
        win_sum = win_sum - row_hist[slot] + row_pixels;
        row_hist[slot] = row_pixels;
        slot = (slot + 1 >= ROWS_IN_WIN) ? 0 : slot + 1;
        rows_done++;
        if (rows_done >= ROWS_IN_WIN && win_sum > top_sum) begin
          top_sum    = win_sum;
          top_centre = rows_done - ROWS_IN_WIN + (ROWS_IN_WIN - 1) / 2;
        end
      end
      col_pos        = 0;
      last_was_floor = 1'b0;
      row_pixels     = 0;
    endfunction

    function void note_pair(logic [7:0] u, logic [7:0] ye, logic [7:0] v, logic [7:0] yo,
                            logic re, logic fe);
      frame_result_t res;
      take_pixel(ye, u, v);
      take_pixel(yo, u, v);
      if (re || fe) close_row();
      if (fe) begin
        res.hit    = top_sum > 0;
        res.centre = res.hit ? BEST_ROW_W'(top_centre) : '0;
        res.total  = (top_sum > SUM_MAX) ? SUM_MAX : SUM_W'(top_sum);
        winners_q.push_back(res);
        clear_frame();
      end
    endfunction

    function void check_result(frame_result_t got);
      frame_result_t want;
      results_seen++;
      if (winners_q.size() == 0) begin
        $display("%0t: unexpected result: best_row %0d best_floor_sum %0d found %0b",
                 $time, got.centre, got.total, got.hit);
        mismatches++;
        return;
      end
      want = winners_q.pop_front();
      if (got.centre !== want.centre) begin
        $display("%0t: best_row expected %0d actual %0d", $time, want.centre, got.centre);
        mismatches++;
      end
      if (got.total !== want.total) begin
        $display("%0t: best_floor_sum expected %0d actual %0d", $time, want.total, got.total);
        mismatches++;
      end
      if (got.hit !== want.hit) begin
        $display("%0t: found expected %0b actual %0b", $time, want.hit, got.hit);
        mismatches++;
      end
    endfunction

    function int pending();
      return winners_q.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // signals
  // --------------------------------------------------------------------------
  logic                  clk;
  logic                  rst;
  logic                  cfg_write;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_stall;
  logic [7:0]            chroma_u;
  logic [7:0]            luma_even;
  logic [7:0]            chroma_v;
  logic [7:0]            luma_odd;
  logic                  row_end;
  logic                  frame_end;
  logic                  out_valid;
  logic                  out_stall;
  logic [BEST_ROW_W-1:0] best_row;
  logic [SUM_W-1:0]      best_floor_sum;
  logic                  found;

  logic    hold_off;
  int      send_idle_pct;
  int      recv_idle_pct;
  int      items_sent;
  int      quiet_cycles;
  bounds_t cur;

  floor_scoreboard #(WIN, MAX_W, MAX_R) sb;

  floor_heading_selector #(
    .WINDOW(WIN),
    .MAX_WIDTH(MAX_W),
    .MAX_ROWS(MAX_R)
  ) dut (.*);

  // clock
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // result side: random stalls, or a long hold-off on request
  initial begin
    int hold_left;
    hold_left = 0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off) hold_left = HOLD_CYCLES;
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // monitor both handshakes and watch for a hang
  always @(posedge clk) begin : monitor
    frame_result_t seen;
    if (rst) begin
      quiet_cycles <= 0;
    end else begin
      if (in_valid && !in_stall)
        sb.note_pair(chroma_u, luma_even, chroma_v, luma_odd, row_end, frame_end);
      if (out_valid && !out_stall) begin
        seen.centre = best_row;
        seen.total  = best_floor_sum;
        seen.hit    = found;
        sb.check_result(seen);
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG) begin
        $display("RESULT: ERROR");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // drivers
  // --------------------------------------------------------------------------
  task automatic send_pair(input logic [7:0] u, input logic [7:0] ye, input logic [7:0] v,
                           input logic [7:0] yo, input logic re, input logic fe);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    chroma_u  <= u;
    luma_even <= ye;
    chroma_v  <= v;
    luma_odd  <= yo;
    row_end   <= re;
    frame_end <= fe;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  // registers are only written with nothing in flight
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    sb.set_reg(idx, val);
    @(posedge clk);
  endtask

  task automatic apply_config(input bounds_t c);
    write_reg(REG_LUMA_LOW, CFG_DATA_W'(c.luma_low));
    write_reg(REG_LUMA_HIGH, CFG_DATA_W'(c.luma_high));
    write_reg(REG_BLUE_DIFF_LOW, CFG_DATA_W'(c.blue_diff_low));
    write_reg(REG_BLUE_DIFF_HIGH, CFG_DATA_W'(c.blue_diff_high));
    write_reg(REG_RED_DIFF_LOW, CFG_DATA_W'(c.red_diff_low));
    write_reg(REG_RED_DIFF_HIGH, CFG_DATA_W'(c.red_diff_high));
    write_reg(REG_ROW_WIDTH, c.row_width);
    write_reg(REG_UNMAPPED, CFG_DATA_W'($urandom_range(511, 0)));
    cfg_write <= 1'b0;
    cur = c;
  endtask

  // a byte inside [lo, hi] when asked and possible, often on a bound
  function automatic logic [7:0] pick_level(logic [7:0] lo, logic [7:0] hi, bit want_in);
    if (!want_in || lo > hi) return 8'($urandom_range(255, 0));
    case ($urandom_range(4))
      0:       return lo;
      1:       return hi;
      default: return 8'($urandom_range(hi, lo));
    endcase
  endfunction

  function automatic int row_pairs();
    int n;
    n = cur.row_width >> 1;
    if (n == 0 || n > 8 || $urandom_range(9) == 0) n = $urandom_range(8, 1);
    return n;
  endfunction

  function automatic int floor_share();
    case ($urandom_range(3))
      0:       return 0;
      1:       return 50;
      2:       return 90;
      default: return 100;
    endcase
  endfunction

  function automatic int frame_rows();
    if ($urandom_range(1) == 0) return $urandom_range(24, 1);
    return $urandom_range(34, WIN);
  endfunction

  // bound sets: wide open, empty, single values, reset, then random
  function automatic bounds_t config_for(int sel);
    bounds_t c;
    c.luma_low       = 8'($urandom_range(160, 0));
    c.luma_high      = 8'($urandom_range(255, c.luma_low));
    c.blue_diff_low  = 8'($urandom_range(160, 0));
    c.blue_diff_high = 8'($urandom_range(255, c.blue_diff_low));
    c.red_diff_low   = 8'($urandom_range(160, 0));
    c.red_diff_high  = 8'($urandom_range(255, c.red_diff_low));
    if ($urandom_range(4) == 0) c.row_width = 9'($urandom_range(511, 0));
    else c.row_width = 9'(2 * $urandom_range(8, 1));
    case (sel)
      0: begin
        c.luma_low       = 8'd0;
        c.luma_high      = 8'd255;
        c.blue_diff_low  = 8'd0;
        c.blue_diff_high = 8'd255;
        c.red_diff_low   = 8'd0;
        c.red_diff_high  = 8'd255;
        c.row_width      = 9'd256;
      end
      1: begin
        c.luma_low       = 8'd255;
        c.luma_high      = 8'd0;
        c.blue_diff_low  = 8'd255;
        c.blue_diff_high = 8'd0;
        c.red_diff_low   = 8'd255;
        c.red_diff_high  = 8'd0;
        c.row_width      = 9'd0;
      end
      2: begin
        c.luma_high      = c.luma_low;
        c.blue_diff_high = c.blue_diff_low;
        c.red_diff_high  = c.red_diff_low;
        c.row_width      = 9'd1;
      end
      3: begin
        c.luma_low       = LUMA_LOW_RST;
        c.luma_high      = LUMA_HIGH_RST;
        c.blue_diff_low  = BLUE_DIFF_LOW_RST;
        c.blue_diff_high = BLUE_DIFF_HIGH_RST;
        c.red_diff_low   = RED_DIFF_LOW_RST;
        c.red_diff_high  = RED_DIFF_HIGH_RST;
        c.row_width      = 9'd2;
      end
      7: c.row_width = 9'd511;
      default: ;
    endcase
    return c;
  endfunction

  // one row of pairs, floor_pct of them aimed inside the bounds
  task automatic send_row(input int pairs, input int floor_pct, input bit closes_frame);
    logic [7:0] u;
    logic [7:0] v;
    logic [7:0] ye;
    logic [7:0] yo;
    bit         hit;
    bit         last;
    for (int p = 0; p < pairs; p++) begin
      hit  = $urandom_range(99) < floor_pct;
      u    = pick_level(cur.blue_diff_low, cur.blue_diff_high, hit);
      v    = pick_level(cur.red_diff_low, cur.red_diff_high, hit);
      ye   = pick_level(cur.luma_low, cur.luma_high, hit && $urandom_range(3) != 0);
      yo   = pick_level(cur.luma_low, cur.luma_high, hit);
      last = (p == pairs - 1);
      send_pair(u, ye, v, yo, last && (!closes_frame || $urandom_range(1) == 1),
                last && closes_frame);
    end
  endtask

  task automatic send_frame(input int rows);
    for (int r = 0; r < rows; r++) send_row(row_pairs(), floor_share(), r == rows - 1);
  endtask

  // result side holds off while single-pair frames keep coming
  task automatic hold_off_burst();
    hold_off <= 1'b1;
    @(posedge clk);
    hold_off <= 1'b0;
    for (int i = 0; i < 30; i++)
      send_pair(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                1'($urandom_range(1)), 1'b1);
  endtask

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    int random_base;
    int sel;
    sb            = new();
    rst           = 1'b1;
    cfg_write     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    in_valid      = 1'b0;
    chroma_u      = '0;
    luma_even     = '0;
    chroma_v      = '0;
    luma_odd      = '0;
    row_end       = 1'b0;
    frame_end     = 1'b0;
    hold_off      = 1'b0;
    send_idle_pct = 6;
    recv_idle_pct = 81;
    items_sent    = 0;
    cur           = sb.bounds;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: field extremes, bound edges, fill edge, frame end cases
    send_pair(8'd0, 8'd0, 8'd0, 8'd0, 1'b1, 1'b1);
    send_pair(8'd255, 8'd255, 8'd255, 8'd255, 1'b1, 1'b0);
    send_pair(8'd120, 8'd255, 8'd130, 8'd100, 1'b0, 1'b0);
    send_pair(8'd121, 8'd50, 8'd0, 8'd50, 1'b0, 1'b0);
    send_pair(8'd0, 8'd101, 8'd131, 8'd0, 1'b1, 1'b0);
    send_pair(8'd120, 8'd100, 8'd130, 8'd101, 1'b0, 1'b0);
    send_pair(8'd0, 8'd255, 8'd0, 8'd0, 1'b0, 1'b1);
    send_pair(8'd60, 8'd0, 8'd60, 8'd255, 1'b1, 1'b1);
    random_base = items_sent;

    // random frames over twelve settings and three idle profiles
    for (sel = 0; sel < 12; sel++) begin
      if (sel == 4) begin
        send_idle_pct = 81;
        recv_idle_pct = 6;
      end else if (sel == 8) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      wait_drained();
      apply_config(config_for(sel));
      if (sel == 0) begin
        // an over-long row clipped at the width limit
        send_row(140, 100, 1'b0);
        send_frame(WIN);
      end
      while (items_sent - random_base < (sel + 1) * RANDOM_ITEMS / 12) send_frame(frame_rows());
      if (sel % 4 == 3) hold_off_burst();
    end
    while (sb.results_seen + sb.pending() < MIN_FRAMES) send_frame(frame_rows());

    // let the last result arrive and make sure nothing follows
    wait_drained();
    repeat (10) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> floor_heading_selector.f
hw/rtl/fhs_pkg.sv
hw/rtl/fhs_row_accum.sv
hw/rtl/fhs_window.sv
hw/rtl/fhs_best.sv
hw/rtl/floor_heading_selector.sv
sim/tb_floor_heading_selector.sv
